// File: rtl/one_bit_linear_chirp_generator_top_defines.svh
// assertion macros for the one-bit chirp generator
// used by the top level; expects i_clk and i_rst_n in the including scope
`ifndef ONE_BIT_LINEAR_CHIRP_GENERATOR_TOP_DEFINES_SVH
`define ONE_BIT_LINEAR_CHIRP_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTH

// checked only while out of reset
`define OLCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define OLCG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define OLCG_ASSERT(lbl, prop, msg)
`define OLCG_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: rtl/olcg_pkg.sv
// shared types, constants and helpers for the one-bit chirp generator
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps

package olcg_pkg;

    localparam int INC_W     = 48;
    localparam int PHASE_W   = 32;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 12;
    localparam int IDX_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_BYTES = 2048;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1250);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_INC  = 2'd0,
        REG_STEP       = 2'd1,
        REG_BYTE_COUNT = 2'd2
    } t_reg_idx;

    // step multiples 1x..8x, entry k holds (k+1) * step
    typedef logic [BYTE_W-1:0][INC_W-1:0] t_step_tab;

    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] phase;
        logic [INC_W-1:0]   inc;
    } t_sweep_in;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [PHASE_W-1:0] phase;
        logic [INC_W-1:0]   inc;
    } t_sweep_out;

    // small constant multiples by shift and add, wrapping modulo 2^48
    function automatic t_step_tab step_table(input logic [INC_W-1:0] s);
        t_step_tab tab;
        tab[0] = s;
        tab[1] = s << 1;
        tab[2] = s + (s << 1);
        tab[3] = s << 2;
        tab[4] = (s << 2) + s;
        tab[5] = (s << 2) + (s << 1);
        tab[6] = (s << 3) - s;
        tab[7] = s << 3;
        return tab;
    endfunction

    // zero counts as one byte, large counts saturate
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        if (n == '0) begin
            r = COUNT_W'(1);
        end else if (n > COUNT_W'(MAX_BYTES)) begin
            r = COUNT_W'(MAX_BYTES);
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

// File: rtl/olcg_intf.sv
// channel interfaces: request, response and configuration write
// depends on olcg_pkg
`timescale 1ns / 1ps

interface olcg_req_if import olcg_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface olcg_rsp_if import olcg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface olcg_cfg_if import olcg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [INC_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/olcg_sweep.sv
// eight-bit sweep datapath: one byte of chirp bits and the next phase/increment
// depends on olcg_pkg; purely combinational, registered by the top level
`timescale 1ns / 1ps

module olcg_sweep import olcg_pkg::*; (
    input  t_sweep_in  i_state,
    input  t_step_tab  i_step_tab,
    input  logic [INC_W-1:0] i_start_inc,
    output t_sweep_out o_result
);

    logic [INC_W-1:0]   inc0;
    logic [PHASE_W-1:0] phase0;
    logic [BYTE_W-1:0][INC_W-1:0]   inc_k;
    logic [BYTE_W-1:0][PHASE_W-1:0] term;
    logic [BYTE_W-1:0][PHASE_W-1:0] psum;
    logic [PHASE_W-1:0] s01, s23, s45, s67, s03, s47, s46;
    logic [BYTE_W-1:0]  bits;
    logic [PHASE_W-1:0] phase_b;

    // chirp start reloads phase and increment
    assign inc0   = i_state.start ? i_start_inc : i_state.inc;
    assign phase0 = i_state.start ? '0 : i_state.phase;

    // increment after each bit, in parallel from the step multiples
    always_comb begin
        for (int k = 0; k < BYTE_W; k++) begin
            inc_k[k] = inc0 + i_step_tab[k];
            term[k]  = inc_k[k][INC_W-1 -: PHASE_W];
        end
    end

    // prefix sums of the phase terms, three adder levels
    assign s01 = term[0] + term[1];
    assign s23 = term[2] + term[3];
    assign s45 = term[4] + term[5];
    assign s67 = term[6] + term[7];
    assign s03 = s01 + s23;
    assign s47 = s45 + s67;
    assign s46 = s45 + term[6];

    always_comb begin
        psum[0] = term[0];
        psum[1] = s01;
        psum[2] = s01 + term[2];
        psum[3] = s03;
        psum[4] = s03 + term[4];
        psum[5] = s03 + s45;
        psum[6] = s03 + s46;
        psum[7] = s03 + s47;
    end

    // bit is one while the phase sits in the first half turn
    always_comb begin
        phase_b = '0;
        bits    = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            if (b == 0) begin
                phase_b = phase0;
            end else begin
                phase_b = phase0 + psum[b-1];
            end
            bits[BYTE_W-1-b] = ~phase_b[PHASE_W-1];
        end
    end

    assign o_result.data_byte = bits;
    assign o_result.phase     = phase0 + psum[BYTE_W-1];
    assign o_result.inc       = inc_k[BYTE_W-1];

endmodule

// File: rtl/one_bit_linear_chirp_generator_top.sv
// top level of the one-bit linear chirp generator
// depends on olcg_pkg, olcg_intf, olcg_sweep and the assertion macro header
//
// usage:
//   i_cfg  - register writes (index 0 start increment, 1 signed step, 2 byte
//            count); always ready; user writes only while idle, unchecked
//   i_req  - one beat per wanted byte; restart = 1 begins a new chirp
//   o_rsp  - one beat per request: data_byte (earliest bit in bit 7) and
//            last on the final byte of the chirp
// timing:
//   a request is accepted in the cycle it is presented while ready; its byte
//   is registered into the output queue and goes out after any waiting byte;
//   one byte per cycle while o_rsp.ready holds, as the eight-bit sweep is one
//   pass of the sweep adders between state registers; the two-entry output
//   queue behind the datapath still takes a request while one byte waits;
//   i_req.ready drops only when both entries are held by a stalled receiver
// reset:
//   phase, increment and byte index clear, count returns to 1250 bytes,
//   the output queue empties; the first request starts a chirp
`timescale 1ns / 1ps
`include "one_bit_linear_chirp_generator_top_defines.svh"

module one_bit_linear_chirp_generator_top import olcg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    olcg_cfg_if.sink           i_cfg,
    olcg_req_if.sink           i_req,
    olcg_rsp_if.source         o_rsp
);

    // configuration registers
    logic [INC_W-1:0]   r_start_inc;
    t_step_tab          r_step_tab;
    logic [COUNT_W-1:0] r_count_eff;

    // chirp state
    logic [PHASE_W-1:0] r_phase;
    logic [INC_W-1:0]   r_inc;
    logic [IDX_W-1:0]   r_byte_index;

    // output queue
    logic [1:0][BYTE_W-1:0] r_q_byte;
    logic [1:0]             r_q_last;
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_cnt;

    logic               cfg_acc;
    logic               in_acc;
    logic               out_acc;
    logic               start;
    logic [IDX_W-1:0]   idx_cur;
    logic [COUNT_W-1:0] idx_next;
    logic               n_last;
    t_sweep_in          sweep_in;
    t_sweep_out         sweep_out;

    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_acc     = o_rsp.valid && o_rsp.ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_inc <= '0;
            r_step_tab  <= '0;
            r_count_eff <= COUNT_RESET;
        end else if (cfg_acc) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_START_INC:  r_start_inc <= i_cfg.data;
                REG_STEP:       r_step_tab  <= step_table(i_cfg.data);
                REG_BYTE_COUNT: r_count_eff <= eff_count(i_cfg.data[COUNT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // chirp start on request or after the final byte
    assign start    = i_req.restart || (r_byte_index == '0);
    assign idx_cur  = start ? '0 : r_byte_index;
    assign idx_next = {1'b0, idx_cur} + COUNT_W'(1);
    assign n_last   = (idx_next >= r_count_eff);

    assign sweep_in.start = start;
    assign sweep_in.phase = r_phase;
    assign sweep_in.inc   = r_inc;

    olcg_sweep u_sweep (
        .i_state     (sweep_in),
        .i_step_tab  (r_step_tab),
        .i_start_inc (r_start_inc),
        .o_result    (sweep_out)
    );

    // state update per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_inc        <= '0;
            r_byte_index <= '0;
        end else if (in_acc) begin
            r_phase      <= sweep_out.phase;
            r_inc        <= sweep_out.inc;
            r_byte_index <= n_last ? '0 : idx_next[IDX_W-1:0];
        end
    end

    // output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_acc) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (in_acc && !out_acc) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!in_acc && out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // output queue payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q_byte[r_wr_ptr] <= sweep_out.data_byte;
            r_q_last[r_wr_ptr] <= n_last;
        end
    end

    assign i_req.ready     = (r_cnt != 2'd2);
    assign o_rsp.valid     = (r_cnt != 2'd0);
    assign o_rsp.data_byte = r_q_byte[r_rd_ptr];
    assign o_rsp.last      = r_q_last[r_rd_ptr];

    // checks
    `OLCG_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_rsp.valid, "output valid right after reset")
    `OLCG_ASSERT(a_push_count, (in_acc && !out_acc) |=> (r_cnt == $past(r_cnt) + 2'd1),
        "queue count did not follow a push")
    `OLCG_ASSERT(a_last_clears, (in_acc && n_last) |=> (r_byte_index == '0),
        "byte index not cleared after final byte")
    `OLCG_ASSERT(a_start_bit, (in_acc && start) |-> sweep_out.data_byte[BYTE_W-1],
        "chirp start byte does not begin with a one bit")
    `OLCG_ASSERT(a_ptr_count, (r_cnt == 2'd0) |-> (r_wr_ptr == r_rd_ptr),
        "queue pointers apart while empty")

endmodule

// File: tb/sv/olcg_chirp_checker.sv
// checker for the one-bit linear chirp generator: watches the three channels,
// predicts every byte and compares it; depends on olcg_pkg and olcg_intf
`timescale 1ns / 1ps

module olcg_chirp_checker import olcg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    olcg_cfg_if  cfg_mon,
    olcg_req_if  req_mon,
    olcg_rsp_if  rsp_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } chirp_byte_t;

    // shadow registers and sweep state
    logic [INC_W-1:0]   start_inc;
    logic [INC_W-1:0]   inc_step;
    logic [COUNT_W-1:0] chirp_len;
    logic [PHASE_W-1:0] phase;
    logic [INC_W-1:0]   inc;
    logic [COUNT_W-1:0] byte_idx;

    chirp_byte_t expected_bytes[$];

    // one byte of the sweep, advancing the shadow state
    task automatic sweep_byte(input logic restart, output chirp_byte_t bytes_out);
        logic [COUNT_W-1:0] limit;
        logic [BYTE_W-1:0]  bits;
        if (chirp_len == '0) begin
            limit = COUNT_W'(1);
        end else if (chirp_len > COUNT_W'(MAX_BYTES)) begin
            limit = COUNT_W'(MAX_BYTES);
        end else begin
            limit = chirp_len;
        end
        if (restart || byte_idx == '0) begin
            phase    = '0;
            inc      = start_inc;
            byte_idx = '0;
        end
        // square wave is high while the phase sits in the first half turn
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            bits[b] = ~phase[PHASE_W-1];
            inc     = inc + inc_step;
            phase   = phase + inc[INC_W-1 -: PHASE_W];
        end
        bytes_out.data_byte = bits;
        bytes_out.last      = (byte_idx + COUNT_W'(1) >= limit);
        byte_idx = bytes_out.last ? '0 : byte_idx + COUNT_W'(1);
    endtask

    always @(posedge i_clk) begin
        chirp_byte_t want;
        chirp_byte_t next_byte;
        if (!i_rst_n) begin
            start_inc = '0;
            inc_step  = '0;
            chirp_len = COUNT_W'(1250);
            phase     = '0;
            inc       = '0;
            byte_idx  = '0;
            expected_bytes.delete();
            o_fail_count <= 0;
        end else begin
            // register writes
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    REG_START_INC:  start_inc = cfg_mon.data;
                    REG_STEP:       inc_step  = cfg_mon.data;
                    REG_BYTE_COUNT: chirp_len = cfg_mon.data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // response beat against the oldest expected byte
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected response beat: data_byte %0h last %0b",
                           rsp_mon.data_byte, rsp_mon.last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (rsp_mon.data_byte !== want.data_byte || rsp_mon.last !== want.last)
                        o_fail_count <= o_fail_count + 1;
                    if (rsp_mon.data_byte !== want.data_byte)
                        $error("data_byte mismatch: expected %02h, actual %02h",
                               want.data_byte, rsp_mon.data_byte);
                    if (rsp_mon.last !== want.last)
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, rsp_mon.last);
                end
            end
            // request beat
            if (req_mon.valid && req_mon.ready) begin
                sweep_byte(req_mon.restart, next_byte);
                expected_bytes.push_back(next_byte);
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// File: tb/sv/tb_one_bit_linear_chirp_generator_top.sv
// testbench top for the one-bit linear chirp generator: clock, reset,
// register programming, request and ready stimulus, watchdog and verdict
// depends on olcg_pkg, olcg_intf, the block and olcg_chirp_checker
`timescale 1ns / 1ps

module tb_one_bit_linear_chirp_generator_top;
    import olcg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 48;
    localparam int HOLD_PHASE     = 2;
    localparam int PAUSE_PHASE    = 5;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_GAP      = 4;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet_tail = 1'b0;
    logic long_hold_req = 1'b0;
    int   fail_count;
    int   pending;
    int   stuck_cycles = 0;

    olcg_cfg_if cfg_if ();
    olcg_req_if req_if ();
    olcg_rsp_if rsp_if ();

    one_bit_linear_chirp_generator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    olcg_chirp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_mon      (cfg_if),
        .req_mon      (req_if),
        .rsp_mon      (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                rsp_if.ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // register write beat; valid stays up for back-to-back writes
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [INC_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic program_chirp(input logic [INC_W-1:0] start_value,
                                 input logic [INC_W-1:0] step_value,
                                 input logic [INC_W-1:0] count_value);
        write_register(REG_START_INC, start_value);
        write_register(REG_STEP, step_value);
        write_register(REG_BYTE_COUNT, count_value);
        cfg_if.valid <= 1'b0;
    endtask

    // request beat; valid stays up for the next request
    task automatic send_request(input logic restart);
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // stop requesting until every predicted byte has come back
    task automatic drain_pending();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    function automatic logic [INC_W-1:0] random_wide();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [INC_W-1:0] random_start();
        logic [INC_W-1:0] v;
        v = random_wide();
        case ($urandom_range(0, 3))
            0: v = {1'b0, v[INC_W-2:0]};
            1: v = {INC_W{1'b0}} | (v >> 12);
            2: v = 48'h8000_0000_0000;
            default: ;
        endcase
        return v;
    endfunction

    // steps are mostly small chirp slopes of either sign
    function automatic logic [INC_W-1:0] random_step();
        logic [INC_W-1:0] v;
        v = random_wide();
        case ($urandom_range(0, 4))
            0: v = {{28{v[19]}}, v[19:0]};
            1: v = {{12{v[35]}}, v[35:0]};
            2: v = '0;
            3: v = {{40{v[7]}}, v[7:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [INC_W-1:0] random_count();
        logic [INC_W-1:0] v;
        v = random_wide();
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = {v[INC_W-1:COUNT_W], 12'hFFF};
            2: v = INC_W'(MAX_BYTES - $urandom_range(0, 1));
            3: v = INC_W'(MAX_BYTES + 1);
            4: v = {v[INC_W-1:COUNT_W], COUNT_W'($urandom_range(1, 24))};
            default: v = INC_W'($urandom_range(1, 24));
        endcase
        return v;
    endfunction

    initial begin
        int gap_odds;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero increment, 1250-byte chirp
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain_pending();

        // half a turn per bit, one-byte chirps
        program_chirp(48'h8000_0000_0000, '0, INC_W'(1));
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain_pending();

        // most negative step, count of zero acts as one
        program_chirp('0, 48'h8000_0000_0000, '0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain_pending();

        // out-of-range values keep their low bits, count saturates,
        // unused register index is ignored
        write_register(REG_START_INC, 48'hFFFF_FFFF_FFFF);
        write_register(REG_STEP, 48'h7FFF_FFFF_FFFF);
        write_register(REG_BYTE_COUNT, 48'hFFFF_FFFF_FFFF);
        write_register(REG_UNUSED, random_wide());
        cfg_if.valid <= 1'b0;
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain_pending();

        // downward sweep, then the count lowered under the running index
        program_chirp(48'h0000_1000_0000, 48'hFFFF_FFFF_FFFF, INC_W'(10));
        repeat (6) send_request(1'b0);
        drain_pending();
        write_register(REG_BYTE_COUNT, INC_W'(3));
        cfg_if.valid <= 1'b0;
        send_request(1'b0);
        send_request(1'b0);
        drain_pending();

        // random phases, each with its own chirp setup
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet_tail = (ph == RANDOM_PHASES - 1);
            gap_odds   = (ph % 2 == 1) ? 3 : 12;
            program_chirp(random_start(), random_step(), random_count());
            if (ph == HOLD_PHASE) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) drain_pending();
                if (!quiet_tail && !(ph == HOLD_PHASE && n < 40) &&
                    $urandom_range(0, gap_odds) == 0) begin
                    req_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
                send_request($urandom_range(0, 11) == 0);
            end
            drain_pending();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
